// ----- src/ils_pkg.sv -----
// Shared types and constants for the indexed list store.
package ils_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned OP_W = 3;
  localparam int unsigned POS_W = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FPOS_W = 6;
  localparam int unsigned FILL_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FIND   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic [FPOS_W-1:0] found_position;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill_count;
  } out_t;

  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] item_value;
  } ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data;
    logic [FPOS_W-1:0] fpos;
  } carry_t;

endpackage

// ----- src/ils_cell.sv -----
// One list cell: holds an entry, shifts with its neighbors and forwards the scan carry.
module ils_cell import ils_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned INDEX    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_t                        ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0] count_i,
  input  logic [WORD_W-1:0]            left_data_i,
  input  logic [WORD_W-1:0]            right_data_i,
  output logic [WORD_W-1:0]            data_o,
  input  carry_t                       carry_i,
  output carry_t                       carry_o
);

  localparam int unsigned CNTW = $clog2(CAPACITY+1);
  localparam int unsigned CMPW = ((CNTW > POS_W) ? CNTW : POS_W) + 1;

  logic [WORD_W-1:0] entry_q, entry_d;
  carry_t            carry_q, carry_d;
  logic [CMPW-1:0]   pos_x, idx_x, cnt_x;
  logic              hit;

  assign pos_x = CMPW'(ctrl_i.position);
  assign idx_x = CMPW'(INDEX);
  assign cnt_x = CMPW'(count_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up) begin
      if (idx_x > pos_x) begin
        entry_d = left_data_i;
      end else if (idx_x == pos_x) begin
        entry_d = ctrl_i.item_value;
      end
    end else if (ctrl_i.shift_down) begin
      if (idx_x >= pos_x) begin
        entry_d = right_data_i;
      end
    end
  end

  always_comb begin
    case (op_e'(ctrl_i.operation))
      OP_GET:  hit = (idx_x == pos_x);
      OP_FIND: hit = (idx_x < cnt_x) && (entry_q == ctrl_i.item_value);
      default: hit = 1'b0;
    endcase
    carry_d = hit ? '{hit: 1'b1, data: entry_q, fpos: FPOS_W'(INDEX)} : carry_i;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign data_o  = entry_q;
  assign carry_o = carry_q;

endmodule

// ----- src/indexed_list_store_top.sv -----
// Top level of the indexed list store: control, fill count, cell chain and output register.
//
// Usage: a positional list of CAPACITY 32-bit words. Each input word on the in_*
// channel carries one operation (insert, remove, get, clear, find) and yields one
// result word on the out_* channel with status and the fill count after the operation.
// Insert and remove shift every cell at or above the position away from or toward it.
// Insert, remove, clear, unused codes and rejected operations: the result sits in the
// output register in the cycle after acceptance.
// Get and find with work to do: each cell tests its entry locally and the lowest hit
// ripples down the cell chain one cell per cycle in the scan state; the finish state
// writes the result into the output register. One operation is in flight at a time;
// one word per cycle for shifting ops unless the output stalls, none during a scan.
// A new word is taken while the previous result is being taken in the same cycle.
// Stall on the output holds the result; no new word is taken until it leaves.
// Reset empties the list (fill count zero) and drops any pending result; entry
// contents are not cleared and are never read until written.
module indexed_list_store_top import ils_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  localparam int unsigned CNTW = $clog2(CAPACITY+1);
  localparam int unsigned SCW  = $clog2(CAPACITY);
  localparam int unsigned CMPW = ((CNTW > POS_W) ? CNTW : POS_W) + 1;

  state_e            state_q, state_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [SCW-1:0]    scan_q, scan_d;
  in_t               req_q;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc, out_take, wr;
  ctrl_t             ctrl;
  logic [CMPW-1:0]   pos_x, cnt_x;
  logic [WORD_W-1:0] data [CAPACITY];
  carry_t            carry [CAPACITY+1];

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_x      = CMPW'(in_i.position);
  assign cnt_x      = CMPW'(count_q);

  always_comb begin
    state_d            = state_q;
    count_d            = count_q;
    scan_d             = scan_q;
    wr                 = 1'b0;
    out_d              = '0;
    ctrl.shift_up      = 1'b0;
    ctrl.shift_down    = 1'b0;
    ctrl.operation     = req_q.operation;
    ctrl.position      = req_q.position;
    ctrl.item_value    = req_q.item_value;
    unique case (state_q)
      S_IDLE: begin
        ctrl.operation  = in_i.operation;
        ctrl.position   = in_i.position;
        ctrl.item_value = in_i.item_value;
        scan_d          = '0;
        if (in_acc) begin
          wr = 1'b1;
          unique case (op_e'(in_i.operation))
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                out_d.status = ST_RANGE;
              end else if (count_q == CNTW'(CAPACITY)) begin
                out_d.status = ST_FULL;
              end else begin
                ctrl.shift_up = 1'b1;
                count_d       = count_q + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pos_x >= cnt_x) begin
                out_d.status = ST_RANGE;
              end else begin
                ctrl.shift_down = 1'b1;
                count_d         = count_q - 1'b1;
              end
            end
            OP_GET: begin
              if (pos_x >= cnt_x) begin
                out_d.status = ST_RANGE;
              end else begin
                wr      = 1'b0;
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: count_d = '0;
            OP_FIND: begin
              wr      = 1'b0;
              state_d = S_SCAN;
            end
            default: out_d.status = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SCW'(CAPACITY - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        wr      = 1'b1;
        state_d = S_IDLE;
        if (op_e'(req_q.operation) == OP_GET) begin
          out_d.read_value = carry[0].data;
        end else if (carry[0].hit) begin
          out_d.found_position = carry[0].fpos;
        end else begin
          out_d.status = ST_MISSING;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_d.fill_count = FILL_W'(count_d);
    out_valid_d = wr ? 1'b1 : (out_take ? 1'b0 : out_valid_q);
    if (!wr) begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      req_q <= in_i;
    end
  end

  assign carry[CAPACITY] = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_W-1:0] left_d, right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = data[k+1];
    end
    ils_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_data_i (left_d),
      .right_data_i(right_d),
      .data_o      (data[k]),
      .carry_i     (carry[k+1]),
      .carry_o     (carry[k])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !out_valid_q)
    else $error("output register busy during scan");

  a_fin_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (out_valid_q && state_q == S_IDLE))
    else $error("scan result not delivered");

endmodule
